FILE: hdl/mvna_pkg.sv
// ----------------------------------------------------------------------------
// mvna_pkg
// Shared types and codes for the mesh vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mvna_pkg;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 24;
  localparam int NRM_W   = 16;
  localparam int COUNT_W = 11;
  localparam int ACC_W   = 64;

  // Item actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_WRITTEN = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_SKIPPED = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic [IDX_W-1:0]        third_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
  } rsp_t;

  // Request into the normalize unit
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
  } norm_req_t;

  // Answer from the normalize unit
  typedef struct packed {
    logic done;
    rsp_t res;
  } norm_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/mvna_norm.sv
// ----------------------------------------------------------------------------
// mvna_norm
// Iterative normalize unit: scale, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module mvna_norm (
  input  wire logic              clk,
  input  wire logic              rst,
  input  mvna_pkg::norm_req_t    req,
  output mvna_pkg::norm_rsp_t    rsp
);
  import mvna_pkg::*;

  typedef enum logic [3:0] {
    N_IDLE, N_MAX, N_SHF, N_SQ, N_SUM, N_SQRT, N_DIVI, N_DIV
  } nstate_t;

  nstate_t            state;
  logic [2:0]         neg;
  logic [63:0]        mag [3];
  logic [63:0]        mx;
  logic [61:0]        sq;
  logic [63:0]        sum;
  logic [1:0]         k;
  logic [63:0]        rad;
  logic [63:0]        root;
  logic [63:0]        bitr;
  logic [4:0]         it;
  logic [46:0]        rem;
  logic [14:0]        quo;
  logic [3:0]         di;
  logic [NRM_W-1:0]   nv [3];

  logic [63:0] mx_next;
  logic [63:0] rb;
  logic [46:0] trial;
  logic        ge;
  logic [14:0] quo_next;
  logic [NRM_W-1:0] nv_next;
  logic        done_next;

  // Largest magnitude, root trial and divide trial
  always_comb begin
    mx_next = mag[0];
    if (mag[1] > mx_next) mx_next = mag[1];
    if (mag[2] > mx_next) mx_next = mag[2];
    rb       = root + bitr;
    trial    = {15'd0, root[31:0]} << di;
    ge       = (rem >= trial);
    quo_next = ge ? (quo | (15'd1 << di)) : quo;
    nv_next  = neg[k] ? NRM_W'(-{1'b0, quo_next}) : {1'b0, quo_next};
    done_next = ((state == N_SHF) && (mx == 64'd0))
             || ((state == N_DIV) && (di == 4'd0) && (k == 2'd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= N_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= done_next;
      case (state)
        N_IDLE: begin
          if (req.start) begin
            neg    <= {req.acc_z[63], req.acc_y[63], req.acc_x[63]};
            mag[0] <= req.acc_x[63] ? 64'(-req.acc_x) : req.acc_x;
            mag[1] <= req.acc_y[63] ? 64'(-req.acc_y) : req.acc_y;
            mag[2] <= req.acc_z[63] ? 64'(-req.acc_z) : req.acc_z;
            state  <= N_MAX;
          end
        end
        N_MAX: begin
          mx    <= mx_next;
          state <= N_SHF;
        end
        // Shift all magnitudes one bit a cycle until the largest fits 31 bits
        N_SHF: begin
          if (mx == 64'd0) begin
            rsp.res.status   <= ST_ZERO;
            rsp.res.normal_x <= '0;
            rsp.res.normal_y <= '0;
            rsp.res.normal_z <= '0;
            state            <= N_IDLE;
          end else if (|mx[63:31]) begin
            mx     <= mx >> 1;
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            k     <= 2'd0;
            sum   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq    <= mag[k][30:0] * mag[k][30:0];
          state <= N_SUM;
        end
        N_SUM: begin
          if (k == 2'd2) begin
            rad   <= sum + {2'b00, sq};
            root  <= '0;
            bitr  <= 64'd1 << 62;
            it    <= '0;
            state <= N_SQRT;
          end else begin
            sum   <= sum + {2'b00, sq};
            k     <= k + 2'd1;
            state <= N_SQ;
          end
        end
        // One root digit per cycle
        N_SQRT: begin
          if (rad >= rb) begin
            rad  <= rad - rb;
            root <= (root >> 1) + bitr;
          end else begin
            root <= root >> 1;
          end
          bitr <= bitr >> 2;
          it   <= it + 5'd1;
          if (it == 5'd31) begin
            k     <= 2'd0;
            state <= N_DIVI;
          end
        end
        N_DIVI: begin
          rem   <= {2'b00, mag[k][30:0], 14'd0} + {16'd0, root[31:1]};
          quo   <= '0;
          di    <= 4'd14;
          state <= N_DIV;
        end
        // Restoring divide, one quotient bit per cycle
        N_DIV: begin
          if (ge) rem <= rem - trial;
          quo <= quo_next;
          di  <= di - 4'd1;
          if (di == 4'd0) begin
            nv[k] <= nv_next;
            if (k == 2'd2) begin
              rsp.res.status   <= ST_READ;
              rsp.res.normal_x <= nv[0];
              rsp.res.normal_y <= nv[1];
              rsp.res.normal_z <= nv_next;
              state            <= N_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= N_DIVI;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mesh_vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Vertex position table with area-weighted normal accumulators.
// ----------------------------------------------------------------------------
// Items enter on req_data under req_valid/req_stall and results leave on
// rsp_data under rsp_valid/rsp_stall, one result per item, in order.
// The user must write vertex_count on cfg_data under cfg_valid/cfg_ready
// only while idle; the block itself does not enforce this. One item is
// worked at a time. A vertex write and a skipped triangle go straight to the
// result; an added triangle does three position reads, six products through
// one 25x25 multiplier and three accumulator read-modify-writes through one
// memory port. A normal read past the table gives a zero result; otherwise the
// normalize unit runs a one-bit-per-cycle scaling shift, 32 root steps and a
// restoring divide per component, or stops early for a zero accumulator.
// The result register lets the next item enter while a result waits.
// While rsp_stall holds, the finished result waits and further items are
// held off with req_stall. Reset clears the control state and
// vertex_count; table entries read before first written are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  mvna_pkg::req_t                     req_data,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output mvna_pkg::rsp_t                     rsp_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mvna_pkg::COUNT_W-1:0]  cfg_data
);
  import mvna_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = (AW > IDX_W) ? AW : IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_VR0, S_VR1, S_VR2, S_VR3, S_MUL, S_ACC,
    S_ARD, S_AWR, S_NRD, S_NST, S_NWT, S_FIN
  } state_t;

  state_t                  state;
  logic [COUNT_W-1:0]      vcount;
  logic [AW-1:0]           caddr [3];
  logic [1:0]              k;
  logic [2:0]              cnt;
  logic signed [POS_W-1:0] p0 [3];
  logic signed [POS_W:0]   ea [3];
  logic signed [POS_W:0]   eb [3];
  logic signed [49:0]      prod;
  logic signed [50:0]      cr [3];
  rsp_t                    res;
  norm_req_t               nreq;
  norm_rsp_t               nrsp;

  logic [3*POS_W-1:0] vmem [MAX_VERTICES];
  logic [3*ACC_W-1:0] amem [MAX_VERTICES];
  logic [3*POS_W-1:0] vrd;
  logic [3*ACC_W-1:0] ard;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [EW-1:0] ext;
    ext = EW'(idx);
    return ext[AW-1:0];
  endfunction

  function automatic logic in_table(input logic [IDX_W-1:0] idx);
    return (32'(idx) < 32'(MAX_VERTICES));
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic signed [50:0] c);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W-50){c[50]}}, c};
    if (s[ACC_W] != s[ACC_W-1])
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s[ACC_W-1:0];
  endfunction

  logic in_ok;
  logic in_lim;
  logic wr_accept;
  logic [AW-1:0] vaddr;
  logic          vwe;
  logic          awe;
  logic [AW-1:0] awa;
  logic [3*ACC_W-1:0] awd;
  logic signed [POS_W:0] opa;
  logic signed [POS_W:0] opb;
  logic [1:0] ck;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign in_ok     = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign ck        = cnt[2:1];

  // Index range checks for a triangle
  always_comb begin
    in_lim = in_table(req_data.first_index)
          && in_table(req_data.second_index)
          && in_table(req_data.third_index)
          && ({1'b0, req_data.first_index} < vcount)
          && ({1'b0, req_data.second_index} < vcount)
          && ({1'b0, req_data.third_index} < vcount);
  end

  assign wr_accept = in_ok && (req_data.action == ACT_WRITE)
                     && in_table(req_data.first_index);

  // Memory port control
  always_comb begin
    case (state)
      S_VR1:   vaddr = caddr[1];
      S_VR2:   vaddr = caddr[2];
      default: vaddr = caddr[0];
    endcase
    vwe = wr_accept;
    if (state == S_AWR) begin
      awe = 1'b1;
      awa = caddr[k];
      awd = {sat_add(ard[3*ACC_W-1:2*ACC_W], cr[0]),
             sat_add(ard[2*ACC_W-1:ACC_W], cr[1]),
             sat_add(ard[ACC_W-1:0], cr[2])};
    end else begin
      awe = wr_accept;
      awa = to_addr(req_data.first_index);
      awd = '0;
    end
    case (cnt)
      3'd0:    begin opa = ea[1]; opb = eb[2]; end
      3'd1:    begin opa = ea[2]; opb = eb[1]; end
      3'd2:    begin opa = ea[2]; opb = eb[0]; end
      3'd3:    begin opa = ea[0]; opb = eb[2]; end
      3'd4:    begin opa = ea[0]; opb = eb[1]; end
      default: begin opa = ea[1]; opb = eb[0]; end
    endcase
  end

  // Position and accumulator memories
  always_ff @(posedge clk) begin
    if (vwe) vmem[to_addr(req_data.first_index)] <=
      {req_data.pos_x, req_data.pos_y, req_data.pos_z};
    vrd <= vmem[vaddr];
    if (awe) amem[awa] <= awd;
    ard <= amem[caddr[k]];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vcount <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nreq.start <= 1'b0;
    end else begin
      nreq.start <= (state == S_NST);
      case (state)
        S_IDLE: begin
          if (in_ok) begin
            caddr[0]     <= to_addr(req_data.first_index);
            caddr[1]     <= to_addr(req_data.second_index);
            caddr[2]     <= to_addr(req_data.third_index);
            k            <= 2'd0;
            cnt          <= 3'd0;
            res.normal_x <= '0;
            res.normal_y <= '0;
            res.normal_z <= '0;
            case (req_data.action)
              ACT_WRITE: begin
                res.status <= ST_WRITTEN;
                state      <= S_FIN;
              end
              ACT_TRI: begin
                if (in_lim) begin
                  state <= S_VR0;
                end else begin
                  res.status <= ST_SKIPPED;
                  state      <= S_FIN;
                end
              end
              ACT_READ: begin
                if (in_table(req_data.first_index)) begin
                  state <= S_NRD;
                end else begin
                  res.status <= ST_ZERO;
                  state      <= S_FIN;
                end
              end
              default: begin
                res.status <= ST_SKIPPED;
                state      <= S_FIN;
              end
            endcase
          end
        end
        // Fetch the three corners and form both edges
        S_VR0: state <= S_VR1;
        S_VR1: begin
          p0[0] <= vrd[3*POS_W-1:2*POS_W];
          p0[1] <= vrd[2*POS_W-1:POS_W];
          p0[2] <= vrd[POS_W-1:0];
          state <= S_VR2;
        end
        S_VR2: begin
          ea[0] <= {vrd[3*POS_W-1], vrd[3*POS_W-1:2*POS_W]} - {p0[0][POS_W-1], p0[0]};
          ea[1] <= {vrd[2*POS_W-1], vrd[2*POS_W-1:POS_W]} - {p0[1][POS_W-1], p0[1]};
          ea[2] <= {vrd[POS_W-1], vrd[POS_W-1:0]} - {p0[2][POS_W-1], p0[2]};
          state <= S_VR3;
        end
        S_VR3: begin
          eb[0] <= {vrd[3*POS_W-1], vrd[3*POS_W-1:2*POS_W]} - {p0[0][POS_W-1], p0[0]};
          eb[1] <= {vrd[2*POS_W-1], vrd[2*POS_W-1:POS_W]} - {p0[1][POS_W-1], p0[1]};
          eb[2] <= {vrd[POS_W-1], vrd[POS_W-1:0]} - {p0[2][POS_W-1], p0[2]};
          state <= S_MUL;
        end
        // Cross product, one product per pass
        S_MUL: begin
          prod  <= opa * opb;
          state <= S_ACC;
        end
        S_ACC: begin
          if (!cnt[0]) cr[ck] <= {prod[49], prod};
          else         cr[ck] <= cr[ck] - {prod[49], prod};
          if (cnt == 3'd5) begin
            state <= S_ARD;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= S_MUL;
          end
        end
        // Read, add and write back each corner's accumulator
        S_ARD: state <= S_AWR;
        S_AWR: begin
          if (k == 2'd2) begin
            k          <= 2'd0;
            res.status <= ST_ADDED;
            state      <= S_FIN;
          end else begin
            k     <= k + 2'd1;
            state <= S_ARD;
          end
        end
        // Normal read through the normalize unit
        S_NRD: state <= S_NST;
        S_NST: begin
          nreq.acc_x <= ard[3*ACC_W-1:2*ACC_W];
          nreq.acc_y <= ard[2*ACC_W-1:ACC_W];
          nreq.acc_z <= ard[ACC_W-1:0];
          state      <= S_NWT;
        end
        S_NWT: begin
          if (nrsp.done) begin
            res   <= nrsp.res;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      rsp_valid <= 1'b1;
      rsp_data  <= res;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  mvna_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

endmodule

`default_nettype wire
